[hdl/mbd_pkg.sv]
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared types, command and register codes and limits of the mouse button
// drag debouncer.
// ----------------------------------------------------------------------------
package mbd_pkg;

  localparam int NUM_BUTTONS_DEF = 6;
  localparam int TIME_BITS_DEF   = 32;
  localparam int MAX_BUTTONS     = 8;

  localparam int IDX_W      = 3;
  localparam int THRESH_W   = 16;
  localparam int COORD_W    = 16;
  localparam int DELTA_W    = 16;
  localparam int STAMP_W    = 32;
  localparam int COUNT_W    = 32;
  localparam int REL_W      = 5;
  localparam int NUM_THRESH = 6;
  localparam int MASK_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 2;

  localparam int HOLD_LIMIT_MS   = 200;
  localparam int DIST_LIMIT_SQ   = 25;
  localparam int DIST_AXIS_MAX   = 5;
  localparam int CONFIRM_WAIT_MS = 150;

  localparam logic [1:0] CMD_EVENT = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_WHEEL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MONITORED    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HYBRID       = 3'd7;

  localparam logic [1:0] SIGN_NONE = 2'd0;
  localparam logic [1:0] SIGN_UP   = 2'd1;
  localparam logic [1:0] SIGN_DOWN = 2'd2;

  typedef logic [2:0] op_kind_t;
  localparam op_kind_t OP_NONE   = 3'd0;
  localparam op_kind_t OP_BUTTON = 3'd1;
  localparam op_kind_t OP_WHEEL  = 3'd2;
  localparam op_kind_t OP_TICK   = 3'd3;
  localparam op_kind_t OP_CLEAR  = 3'd4;

  typedef struct packed {
    logic [NUM_THRESH-1:0][THRESH_W-1:0] thresh;
    logic [MASK_W-1:0]                   monitored;
    logic                                hybrid;
  } cfg_t;

  typedef struct packed {
    op_kind_t                   kind;
    logic [IDX_W-1:0]           idx;
    logic                       idx_valid;
    logic                       is_down;
    logic [1:0]                 wheel_sign;
    logic [THRESH_W-1:0]        window;
    logic                       hybrid;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic [STAMP_W-1:0]         stamp;
  } op_t;

endpackage

[hdl/mouse_button_drag_debouncer.sv]
// ----------------------------------------------------------------------------
// mouse_button_drag_debouncer
// Debounces five mouse buttons and a wheel with drag protection and keeps
// per-button and total block counts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries events, ticks and clear
//   commands; each transfer yields exactly one result transfer on the
//   output channel (out_valid/out_ready) with the block flag, the release
//   mask of a tick, the addressed button's block count and the total.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata while no
//   transfer is in flight; registers 0..5 are windows, 6 the monitored
//   mask, 7 the hybrid enable.
//   A result passes through the queue and is then registered in the
//   execution stage.
//   Throughput: one item per cycle while the result register is empty or
//   out_ready is high; the per-button state update is combinational.
//   A two-entry queue sits between the classifier and the execution
//   stage. When out_ready is low the result register holds, the queue
//   fills, and in_ready drops once both entries are taken.
//   Reset (rst_n low, synchronous) empties the queue and the result
//   register, sets every button idle, clears counts, last event times and
//   wheel direction, zeroes the windows and mask, and enables hybrid mode.
// ----------------------------------------------------------------------------
module mouse_button_drag_debouncer #(
  parameter int NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEF,
  parameter int TIME_BITS   = mbd_pkg::TIME_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mbd_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_cmd,
  input  logic [mbd_pkg::IDX_W-1:0]             in_button_index,
  input  logic                                  in_is_down,
  input  logic                                  in_is_injected,
  input  logic signed [mbd_pkg::DELTA_W-1:0]    in_wheel_delta,
  input  logic signed [mbd_pkg::COORD_W-1:0]    in_pos_x,
  input  logic signed [mbd_pkg::COORD_W-1:0]    in_pos_y,
  input  logic [mbd_pkg::STAMP_W-1:0]           in_event_time_ms,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_block,
  output logic [mbd_pkg::REL_W-1:0]             out_release_mask,
  output logic [mbd_pkg::COUNT_W-1:0]           out_button_blocks,
  output logic [mbd_pkg::COUNT_W-1:0]           out_total_blocks
);
  import mbd_pkg::*;

  cfg_t  cfg;
  op_t   q_op;
  logic  q_valid;
  logic  q_pop;

  mbd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mbd_front #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_button_index  (in_button_index),
    .in_is_down       (in_is_down),
    .in_is_injected   (in_is_injected),
    .in_wheel_delta   (in_wheel_delta),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_event_time_ms (in_event_time_ms),
    .cfg              (cfg),
    .q_valid          (q_valid),
    .q_op             (q_op),
    .q_pop            (q_pop)
  );

  mbd_back #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_op              (q_op),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_block         (out_block),
    .out_release_mask  (out_release_mask),
    .out_button_blocks (out_button_blocks),
    .out_total_blocks  (out_total_blocks)
  );

  // A clear command must leave the running total at zero.
  a_clear_zeroes_total: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_op.kind == OP_CLEAR) |=> (out_valid && out_total_blocks == '0))
    else $error("total block count not zero after clear");

  // A tick never blocks, and no event result carries a release mask.
  a_mask_only_unblocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_release_mask != '0) |-> !out_block)
    else $error("release mask reported together with a block");

  // Back-pressure on the input only arises with work queued.
  a_stall_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (q_valid && out_valid))
    else $error("input stalled with nothing queued");

  // Work is taken from the queue only when the result register can accept it.
  a_pop_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !q_pop)
    else $error("result overwritten while stalled");

endmodule

[hdl/mbd_cfg.sv]
// ----------------------------------------------------------------------------
// mbd_cfg
// Configuration registers: bounce windows, monitored mask and hybrid enable.
// ----------------------------------------------------------------------------
module mbd_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output mbd_pkg::cfg_t                     cfg
);
  import mbd_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      if (cfg_index == CFG_MONITORED) begin
        cfg_nxt.monitored = cfg_wdata[MASK_W-1:0];
      end else if (cfg_index == CFG_HYBRID) begin
        cfg_nxt.hybrid = cfg_wdata[0];
      end else begin
        cfg_nxt.thresh[cfg_index] = cfg_wdata[THRESH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thresh    <= '0;
      cfg_r.monitored <= '0;
      cfg_r.hybrid    <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hdl/mbd_front.sv]
// ----------------------------------------------------------------------------
// mbd_front
// Accepts input items, classifies them into operations and holds them in a
// short queue for the execution side.
// ----------------------------------------------------------------------------
module mbd_front #(
  parameter int NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_cmd,
  input  logic [mbd_pkg::IDX_W-1:0]             in_button_index,
  input  logic                                  in_is_down,
  input  logic                                  in_is_injected,
  input  logic signed [mbd_pkg::DELTA_W-1:0]    in_wheel_delta,
  input  logic signed [mbd_pkg::COORD_W-1:0]    in_pos_x,
  input  logic signed [mbd_pkg::COORD_W-1:0]    in_pos_y,
  input  logic [mbd_pkg::STAMP_W-1:0]           in_event_time_ms,
  input  mbd_pkg::cfg_t                         cfg,
  output logic                                  q_valid,
  output mbd_pkg::op_t                          q_op,
  input  logic                                  q_pop
);
  import mbd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] WHEEL_IDX = IDX_W'(NUM_BUTTONS - 1);

  op_t                op_new;
  logic [MAX_BUTTONS-1:0] mon_ext;
  logic               idx_in_range;
  logic               monitored;

  op_t                queue_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]     count_r, count_nxt;
  logic               push;

  // Classification depends only on the item and the configuration.
  always_comb begin
    mon_ext      = MAX_BUTTONS'(cfg.monitored);
    idx_in_range = {1'b0, in_button_index} < (IDX_W + 1)'(NUM_BUTTONS);
    monitored    = idx_in_range && !in_is_injected && mon_ext[in_button_index];

    op_new            = '0;
    op_new.idx        = in_button_index;
    op_new.idx_valid  = idx_in_range;
    op_new.is_down    = in_is_down;
    op_new.hybrid     = cfg.hybrid;
    op_new.pos_x      = in_pos_x;
    op_new.pos_y      = in_pos_y;
    op_new.stamp      = in_event_time_ms;
    op_new.wheel_sign = (in_wheel_delta == '0) ? SIGN_NONE :
                        (in_wheel_delta[DELTA_W-1] ? SIGN_DOWN : SIGN_UP);

    if (in_button_index == WHEEL_IDX) begin
      op_new.window = cfg.thresh[CFG_THRESH_WHEEL];
    end else if (in_button_index < IDX_W'(REL_W)) begin
      op_new.window = cfg.thresh[in_button_index];
    end else begin
      op_new.window = '0;
    end

    case (in_cmd)
      CMD_EVENT: begin
        if (!monitored) begin
          op_new.kind = OP_NONE;
        end else if (in_button_index == WHEEL_IDX) begin
          op_new.kind = (op_new.wheel_sign == SIGN_NONE) ? OP_NONE : OP_WHEEL;
        end else begin
          op_new.kind = OP_BUTTON;
        end
      end
      CMD_TICK:  op_new.kind = OP_TICK;
      CMD_CLEAR: op_new.kind = OP_CLEAR;
      default:   op_new.kind = OP_NONE;
    endcase
  end

  assign in_ready = (count_r != (PTR_W + 1)'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_op     = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + (PTR_W + 1)'(push) - (PTR_W + 1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= op_new;
    end
  end

endmodule

[hdl/mbd_back.sv]
// ----------------------------------------------------------------------------
// mbd_back
// Executes classified operations against the per-button state and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module mbd_back #(
  parameter int NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEF,
  parameter int TIME_BITS   = mbd_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  mbd_pkg::op_t                      q_op,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_block,
  output logic [mbd_pkg::REL_W-1:0]         out_release_mask,
  output logic [mbd_pkg::COUNT_W-1:0]       out_button_blocks,
  output logic [mbd_pkg::COUNT_W-1:0]       out_total_blocks
);
  import mbd_pkg::*;

  localparam int IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_PRESSED    = 3'd1;
  localparam logic [2:0] PH_DRAGGING   = 3'd2;
  localparam logic [2:0] PH_CONFIRMING = 3'd3;
  localparam logic [2:0] PH_BLOCKED    = 3'd4;

  localparam logic [TIME_BITS-1:0] HOLD_LIMIT   = TIME_BITS'(HOLD_LIMIT_MS);
  localparam logic [TIME_BITS-1:0] CONFIRM_WAIT = TIME_BITS'(CONFIRM_WAIT_MS);
  localparam logic [COORD_W:0]     AXIS_MAX     = (COORD_W + 1)'(DIST_AXIS_MAX);
  localparam logic [6:0]           DIST_LIMIT   = 7'(DIST_LIMIT_SQ);

  logic [2:0]              phase_r   [NUM_BUTTONS];
  logic [2:0]              phase_nxt [NUM_BUTTONS];
  logic [TIME_BITS-1:0]    last_r    [NUM_BUTTONS];
  logic [TIME_BITS-1:0]    last_nxt  [NUM_BUTTONS];
  logic [TIME_BITS-1:0]    press_t_r [NUM_BUTTONS];
  logic [TIME_BITS-1:0]    press_t_nxt [NUM_BUTTONS];
  logic signed [COORD_W-1:0] px_r    [NUM_BUTTONS];
  logic signed [COORD_W-1:0] px_nxt  [NUM_BUTTONS];
  logic signed [COORD_W-1:0] py_r    [NUM_BUTTONS];
  logic signed [COORD_W-1:0] py_nxt  [NUM_BUTTONS];
  logic [TIME_BITS-1:0]    conf_r    [NUM_BUTTONS];
  logic [TIME_BITS-1:0]    conf_nxt  [NUM_BUTTONS];
  logic [COUNT_W-1:0]      cnt_r     [NUM_BUTTONS];
  logic [COUNT_W-1:0]      cnt_nxt   [NUM_BUTTONS];
  logic [1:0]              sign_r, sign_nxt;
  logic [COUNT_W-1:0]      total_r, total_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_block_r;
  logic [REL_W-1:0]        out_rel_r;
  logic [COUNT_W-1:0]      out_btn_r;
  logic [COUNT_W-1:0]      out_total_r;

  logic [IW-1:0]           sel;
  logic [TIME_BITS-1:0]    now;
  logic [2:0]              ph;
  logic [TIME_BITS-1:0]    elapsed;
  logic [TIME_BITS-1:0]    held;
  logic                    in_window;
  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W:0]        adx, ady;
  logic [5:0]              sqx, sqy;
  logic [6:0]              d2;
  logic                    moved;
  logic                    defer;
  logic                    blk, inc, clr, press_upd;
  logic [MAX_BUTTONS-1:0]  fire;
  logic [REL_W-1:0]        rel;
  logic [COUNT_W-1:0]      btn_count;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  assign sel       = q_op.idx[IW-1:0];
  assign now       = TIME_BITS'(q_op.stamp);
  assign ph        = phase_r[sel];
  assign elapsed   = now - last_r[sel];
  assign held      = now - press_t_r[sel];
  assign in_window = elapsed <= TIME_BITS'(q_op.window);

  // Distance test without a wide multiply: an axis off by more than the
  // limit is enough on its own, otherwise both offsets are tiny.
  always_comb begin
    dx    = {q_op.pos_x[COORD_W-1], q_op.pos_x} - {px_r[sel][COORD_W-1], px_r[sel]};
    dy    = {q_op.pos_y[COORD_W-1], q_op.pos_y} - {py_r[sel][COORD_W-1], py_r[sel]};
    adx   = dx[COORD_W] ? (COORD_W + 1)'(-dx) : (COORD_W + 1)'(dx);
    ady   = dy[COORD_W] ? (COORD_W + 1)'(-dy) : (COORD_W + 1)'(dy);
    sqx   = 6'(adx[2:0] * adx[2:0]);
    sqy   = 6'(ady[2:0] * ady[2:0]);
    d2    = 7'(sqx) + 7'(sqy);
    moved = (adx > AXIS_MAX) || (ady > AXIS_MAX) || (d2 > DIST_LIMIT);
    defer = q_op.hybrid &&
            ((ph == PH_DRAGGING) || (held > HOLD_LIMIT) || moved);
  end

  always_comb begin
    phase_nxt   = phase_r;
    last_nxt    = last_r;
    press_t_nxt = press_t_r;
    px_nxt      = px_r;
    py_nxt      = py_r;
    conf_nxt    = conf_r;
    cnt_nxt     = cnt_r;
    sign_nxt    = sign_r;
    blk         = 1'b0;
    inc         = 1'b0;
    clr         = 1'b0;
    press_upd   = 1'b0;
    fire        = '0;

    case (q_op.kind)
      OP_BUTTON: begin
        last_nxt[sel] = now;
        if (q_op.is_down) begin
          if (ph == PH_CONFIRMING) begin
            phase_nxt[sel] = PH_DRAGGING;
            press_upd      = 1'b1;
            blk            = 1'b1;
            inc            = 1'b1;
          end else if (ph == PH_BLOCKED) begin
            blk = 1'b1;
            inc = 1'b1;
          end else if (in_window) begin
            phase_nxt[sel] = PH_BLOCKED;
            blk            = 1'b1;
            inc            = 1'b1;
          end else begin
            phase_nxt[sel] = PH_PRESSED;
            press_upd      = 1'b1;
          end
        end else begin
          if (ph == PH_BLOCKED) begin
            phase_nxt[sel] = PH_IDLE;
            blk            = 1'b1;
            inc            = 1'b1;
          end else if (ph == PH_CONFIRMING) begin
            blk = 1'b1;
            inc = 1'b1;
          end else if ((ph == PH_PRESSED || ph == PH_DRAGGING) && defer) begin
            // A deferred release is suppressed but not counted.
            phase_nxt[sel] = PH_CONFIRMING;
            conf_nxt[sel]  = now;
            blk            = 1'b1;
          end else begin
            phase_nxt[sel] = PH_IDLE;
          end
        end
        if (press_upd) begin
          press_t_nxt[sel] = now;
          px_nxt[sel]      = q_op.pos_x;
          py_nxt[sel]      = q_op.pos_y;
        end
      end
      OP_WHEEL: begin
        // The wheel is the last index, so sel already points at its state.
        if (sign_r != SIGN_NONE && sign_r != q_op.wheel_sign && in_window) begin
          blk = 1'b1;
          inc = 1'b1;
        end
        sign_nxt      = q_op.wheel_sign;
        last_nxt[sel] = now;
      end
      OP_TICK: begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          if (phase_r[i] == PH_CONFIRMING && (now - conf_r[i]) >= CONFIRM_WAIT) begin
            phase_nxt[i] = PH_IDLE;
            fire[i]      = 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        clr = 1'b1;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          phase_nxt[i] = PH_IDLE;
          cnt_nxt[i]   = '0;
        end
        sign_nxt = SIGN_NONE;
      end
      default: begin
      end
    endcase

    if (inc) begin
      cnt_nxt[sel] = cnt_r[sel] + COUNT_W'(1);
    end
    total_nxt = clr ? '0 : total_r + COUNT_W'(inc);
    rel       = fire[REL_W-1:0];
    btn_count = q_op.idx_valid ? cnt_nxt[sel] : '0;
  end

  always_comb begin
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        phase_r[i] <= PH_IDLE;
        last_r[i]  <= '0;
        cnt_r[i]   <= '0;
      end
      sign_r      <= SIGN_NONE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r <= phase_nxt;
        last_r  <= last_nxt;
        cnt_r   <= cnt_nxt;
        sign_r  <= sign_nxt;
        total_r <= total_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Press and confirm records are always written before they are read.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      press_t_r   <= press_t_nxt;
      px_r        <= px_nxt;
      py_r        <= py_nxt;
      conf_r      <= conf_nxt;
      out_block_r <= blk;
      out_rel_r   <= rel;
      out_btn_r   <= btn_count;
      out_total_r <= total_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_block         = out_block_r;
  assign out_release_mask  = out_rel_r;
  assign out_button_blocks = out_btn_r;
  assign out_total_blocks  = out_total_r;

endmodule
